FILE: rtl/core/usb_aat_pkg.sv
// Shared types and constants of the USB address allocator table.
`timescale 1ns / 1ps

package usb_aat_pkg;

    localparam int ADDR_W   = 7;
    localparam int HANDLE_W = 32;
    localparam int OP_W     = 3;
    localparam int SPEED_W  = 2;
    localparam int STATUS_W = 2;

    localparam logic [OP_W-1:0] OP_ALLOCATE   = 3'd0;
    localparam logic [OP_W-1:0] OP_BIND       = 3'd1;
    localparam logic [OP_W-1:0] OP_RELEASE    = 3'd2;
    localparam logic [OP_W-1:0] OP_FIND_HNDL  = 3'd3;
    localparam logic [OP_W-1:0] OP_FIND_ADDR  = 3'd4;
    localparam logic [OP_W-1:0] OP_GET_SPEED  = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK          = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_SPACE    = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NOT_FOUND   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_REQUEST = 2'd3;

    localparam logic [SPEED_W-1:0] SPEED_UNKNOWN = 2'd3;

    typedef enum logic [2:0] {
        K_ALLOC   = 3'd0,
        K_BIND    = 3'd1,
        K_RELEASE = 3'd2,
        K_FIND_H  = 3'd3,
        K_FIND_A  = 3'd4,
        K_SPEED   = 3'd5,
        K_BAD     = 3'd6
    } t_kind;

    typedef struct packed {
        logic [OP_W-1:0]     op;
        logic [ADDR_W-1:0]   dev_address;
        logic [HANDLE_W-1:0] dev_handle;
        logic [SPEED_W-1:0]  dev_speed;
    } t_in_item;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [ADDR_W-1:0]   result_address;
        logic [HANDLE_W-1:0] result_handle;
        logic [SPEED_W-1:0]  result_speed;
    } t_out_item;

    typedef struct packed {
        t_kind               kind;
        logic [ADDR_W-1:0]   addr;
        logic [HANDLE_W-1:0] handle;
        logic [SPEED_W-1:0]  speed;
        logic                in_table;
        logic                usable;
    } t_cmd;

endpackage

FILE: rtl/core/usb_aat_if.sv
// Valid/ready channel carrying one item.
`timescale 1ns / 1ps

interface usb_aat_if #(
    parameter type t_payload = logic
) ();
    logic     valid;
    logic     ready;
    t_payload data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: rtl/core/usb_aat_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module usb_aat_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

FILE: rtl/core/usb_aat_front.sv
// Request intake: decode and range-check items, hold them in a two-entry queue.
`timescale 1ns / 1ps

module usb_aat_front #(
    parameter int ADDRESS_COUNT = 128
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    usb_aat_if.sink             i_req,
    output usb_aat_pkg::t_cmd   o_cmd,
    output logic                o_cmd_valid,
    input  logic                i_cmd_pop
);
    import usb_aat_pkg::*;

    localparam logic [ADDR_W-1:0] TOP = ADDR_W'(ADDRESS_COUNT - 1);

    t_cmd       r_q [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;
    t_cmd       w_cmd;
    logic       w_push;
    logic       w_pop;

    always_comb begin
        w_cmd.addr     = i_req.data.dev_address;
        w_cmd.handle   = i_req.data.dev_handle;
        w_cmd.speed    = i_req.data.dev_speed;
        w_cmd.in_table = (i_req.data.dev_address <= TOP);
        w_cmd.usable   = w_cmd.in_table && (i_req.data.dev_address != '0);
        case (i_req.data.op)
            OP_ALLOCATE:  w_cmd.kind = K_ALLOC;
            OP_BIND:      w_cmd.kind = K_BIND;
            OP_RELEASE:   w_cmd.kind = K_RELEASE;
            OP_FIND_HNDL: w_cmd.kind = K_FIND_H;
            OP_FIND_ADDR: w_cmd.kind = K_FIND_A;
            OP_GET_SPEED: w_cmd.kind = K_SPEED;
            default:      w_cmd.kind = K_BAD;
        endcase
    end

    assign i_req.ready = (r_cnt != 2'd2);
    assign w_push      = i_req.valid && i_req.ready;
    assign w_pop       = i_cmd_pop && (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign o_cmd_valid = (r_cnt != 2'd0);

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wp] <= w_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (w_push) begin
                r_wp <= ~r_wp;
            end
            if (w_pop) begin
                r_rp <= ~r_rp;
            end
            case ({w_push, w_pop})
                2'b10:   r_cnt <= r_cnt + 2'd1;
                2'b01:   r_cnt <= r_cnt - 2'd1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end
endmodule

FILE: rtl/core/usb_aat_back.sv
// Request execution: table state, address and handle scans, result register.
`timescale 1ns / 1ps

module usb_aat_back #(
    parameter int ADDRESS_COUNT = 128,
    parameter int HANDLE_WIDTH  = 32
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  usb_aat_pkg::t_cmd   i_cmd,
    input  logic                i_cmd_valid,
    output logic                o_cmd_pop,
    usb_aat_if.source           o_rsp
);
    import usb_aat_pkg::*;

    localparam int AW    = $clog2(ADDRESS_COUNT);
    localparam int DEPTH = 1 << AW;
    localparam logic [ADDR_W-1:0] TOP = ADDR_W'(ADDRESS_COUNT - 1);
    localparam logic [ADDR_W-1:0] ONE = ADDR_W'(1);

    typedef enum logic [5:0] {
        S_IDLE  = 6'b000001,
        S_START = 6'b000010,
        S_ALLOC = 6'b000100,
        S_HSCAN = 6'b001000,
        S_READ  = 6'b010000,
        S_EMIT  = 6'b100000
    } t_state;

    t_state             r_state, n_state;
    t_cmd               r_cmd, n_cmd;
    logic [DEPTH-1:0]   r_occ, n_occ;
    logic [DEPTH-1:0]   r_hvld, n_hvld;
    logic [DEPTH-1:0]   r_svld, n_svld;
    logic [ADDR_W-1:0]  r_last, n_last;
    logic [ADDR_W-1:0]  r_cand, n_cand;
    logic [ADDR_W-1:0]  r_tries, n_tries;
    logic [ADDR_W-1:0]  r_chk, n_chk;
    logic               r_chk_v, n_chk_v;
    t_out_item          r_res, n_res;
    t_out_item          r_out, n_out;
    logic               r_out_valid, n_out_valid;

    logic                    w_h_we;
    logic [AW-1:0]           w_h_raddr;
    logic [HANDLE_WIDTH-1:0] w_h_rdata;
    logic [HANDLE_WIDTH-1:0] w_hnd;
    logic [HANDLE_WIDTH-1:0] w_hval_chk;
    logic [HANDLE_WIDTH-1:0] w_hval_cmd;
    logic                    w_s_we;
    logic [AW-1:0]           w_s_waddr;
    logic [SPEED_W-1:0]      w_s_rdata;
    logic [AW-1:0]           w_cmd_idx;
    logic [AW-1:0]           w_cand_idx;
    logic [AW-1:0]           w_chk_idx;
    logic                    w_out_free;

    assign w_cmd_idx  = r_cmd.addr[AW-1:0];
    assign w_cand_idx = r_cand[AW-1:0];
    assign w_chk_idx  = r_chk[AW-1:0];
    assign w_hnd      = HANDLE_WIDTH'(r_cmd.handle);
    assign w_h_raddr  = (r_state == S_HSCAN) ? w_cand_idx : w_cmd_idx;
    assign w_hval_chk = r_hvld[w_chk_idx] ? w_h_rdata : '0;
    assign w_hval_cmd = r_hvld[w_cmd_idx] ? w_h_rdata : '0;
    assign w_out_free = !r_out_valid || o_rsp.ready;

    usb_aat_ram #(
        .WIDTH (HANDLE_WIDTH),
        .DEPTH (DEPTH)
    ) u_handle_ram (
        .i_clk   (i_clk),
        .i_we    (w_h_we),
        .i_waddr (w_cmd_idx),
        .i_wdata (w_hnd),
        .i_raddr (w_h_raddr),
        .o_rdata (w_h_rdata)
    );

    usb_aat_ram #(
        .WIDTH (SPEED_W),
        .DEPTH (DEPTH)
    ) u_speed_ram (
        .i_clk   (i_clk),
        .i_we    (w_s_we),
        .i_waddr (w_s_waddr),
        .i_wdata (r_cmd.speed),
        .i_raddr (w_cmd_idx),
        .o_rdata (w_s_rdata)
    );

    always_comb begin
        n_state     = r_state;
        n_cmd       = r_cmd;
        n_occ       = r_occ;
        n_hvld      = r_hvld;
        n_svld      = r_svld;
        n_last      = r_last;
        n_cand      = r_cand;
        n_tries     = r_tries;
        n_chk       = r_chk;
        n_chk_v     = r_chk_v;
        n_res       = r_res;
        n_out       = r_out;
        n_out_valid = r_out_valid;
        o_cmd_pop   = 1'b0;
        w_h_we      = 1'b0;
        w_s_we      = 1'b0;
        w_s_waddr   = w_cand_idx;

        if (r_out_valid && o_rsp.ready) begin
            n_out_valid = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (i_cmd_valid) begin
                    n_cmd     = i_cmd;
                    o_cmd_pop = 1'b1;
                    n_state   = S_START;
                end
            end
            S_START: begin
                n_res   = '0;
                n_state = S_EMIT;
                case (r_cmd.kind)
                    K_ALLOC: begin
                        n_cand  = (r_last >= TOP) ? ONE : r_last + ONE;
                        n_tries = '0;
                        n_state = S_ALLOC;
                    end
                    K_BIND: begin
                        if (r_cmd.usable && r_occ[w_cmd_idx]) begin
                            w_h_we              = 1'b1;
                            n_hvld[w_cmd_idx]   = 1'b1;
                            n_res.status        = ST_OK;
                        end else begin
                            n_res.status = ST_BAD_REQUEST;
                        end
                    end
                    K_RELEASE: begin
                        if (r_cmd.usable && r_occ[w_cmd_idx]) begin
                            n_occ[w_cmd_idx] = 1'b0;
                            n_res.status     = ST_OK;
                        end else begin
                            n_res.status = ST_BAD_REQUEST;
                        end
                    end
                    K_FIND_H: begin
                        n_cand  = ONE;
                        n_chk_v = 1'b0;
                        n_state = S_HSCAN;
                    end
                    K_FIND_A, K_SPEED: begin
                        n_state = S_READ;
                    end
                    default: begin
                        n_res.status = ST_BAD_REQUEST;
                    end
                endcase
            end
            S_ALLOC: begin
                if (!r_occ[w_cand_idx]) begin
                    n_occ[w_cand_idx]  = 1'b1;
                    n_svld[w_cand_idx] = 1'b1;
                    w_s_we             = 1'b1;
                    n_last             = r_cand;
                    n_res.status       = ST_OK;
                    n_res.result_address = r_cand;
                    n_state            = S_EMIT;
                end else if (r_tries == TOP - ONE) begin
                    n_res.status = ST_NO_SPACE;
                    n_state      = S_EMIT;
                end else begin
                    n_cand  = (r_cand >= TOP) ? ONE : r_cand + ONE;
                    n_tries = r_tries + ONE;
                end
            end
            S_HSCAN: begin
                n_chk   = r_cand;
                n_chk_v = 1'b1;
                n_cand  = r_cand + ONE;
                if (r_chk_v) begin
                    if (r_occ[w_chk_idx] && (w_hval_chk == w_hnd)) begin
                        n_res.status         = ST_OK;
                        n_res.result_address = r_chk;
                        n_state              = S_EMIT;
                    end else if (r_chk == TOP) begin
                        n_res.status = ST_NOT_FOUND;
                        n_state      = S_EMIT;
                    end
                end
            end
            S_READ: begin
                n_state = S_EMIT;
                if (r_cmd.kind == K_FIND_A) begin
                    if (!r_cmd.in_table || !r_occ[w_cmd_idx]) begin
                        n_res.status = ST_NOT_FOUND;
                    end else begin
                        n_res.status         = ST_OK;
                        n_res.result_address = r_cmd.addr;
                        n_res.result_handle  = HANDLE_W'(w_hval_cmd);
                    end
                end else begin
                    if (!r_cmd.in_table) begin
                        n_res.status = ST_BAD_REQUEST;
                    end else begin
                        n_res.status       = ST_OK;
                        n_res.result_speed = r_svld[w_cmd_idx] ? w_s_rdata : SPEED_UNKNOWN;
                    end
                end
            end
            S_EMIT: begin
                if (w_out_free) begin
                    n_out       = r_res;
                    n_out_valid = 1'b1;
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_cmd   <= n_cmd;
        r_cand  <= n_cand;
        r_tries <= n_tries;
        r_chk   <= n_chk;
        r_res   <= n_res;
        r_out   <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_occ       <= DEPTH'(1);
            r_hvld      <= '0;
            r_svld      <= '0;
            r_last      <= '0;
            r_chk_v     <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_occ       <= n_occ;
            r_hvld      <= n_hvld;
            r_svld      <= n_svld;
            r_last      <= n_last;
            r_chk_v     <= n_chk_v;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_rsp.valid = r_out_valid;
    assign o_rsp.data  = r_out;
endmodule

FILE: rtl/core/usb_address_allocator_table.sv
// Each item passes S_START and S_EMIT; find_by_address and get_speed also pass S_READ.
// allocate scans in S_ALLOC, one table entry probed per cycle.
// find_by_handle scans in S_HSCAN, one handle RAM read per cycle.
// The execution unit holds one item at a time and waits in S_EMIT while the output stalls;
// two more queue at the front. Reset: occupancy and written-entry flags clear directly,
// address 0 occupied, no clearing pass; unwritten handles read as 0, speeds as unknown.
`timescale 1ns / 1ps

module usb_address_allocator_table #(
    parameter int ADDRESS_COUNT = 128,
    parameter int HANDLE_WIDTH  = 32
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    usb_aat_if.sink   i_req,
    usb_aat_if.source o_rsp
);
    import usb_aat_pkg::*;

    t_cmd w_cmd;
    logic w_cmd_valid;
    logic w_cmd_pop;

    usb_aat_front #(
        .ADDRESS_COUNT (ADDRESS_COUNT)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_req       (i_req),
        .o_cmd       (w_cmd),
        .o_cmd_valid (w_cmd_valid),
        .i_cmd_pop   (w_cmd_pop)
    );

    usb_aat_back #(
        .ADDRESS_COUNT (ADDRESS_COUNT),
        .HANDLE_WIDTH  (HANDLE_WIDTH)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_cmd_valid (w_cmd_valid),
        .o_cmd_pop   (w_cmd_pop),
        .o_rsp       (o_rsp)
    );
endmodule

FILE: tb/sv/tb.sv
// Self-checking testbench for the USB address allocator table.
`timescale 1ns / 1ps

module tb;
    import usb_aat_pkg::*;

    localparam int TABLE_SIZE     = 128;
    localparam int TOP_ADDR       = TABLE_SIZE - 1;
    localparam int RANDOM_ITEMS   = 1700;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 2 * TABLE_SIZE;

    localparam logic [OP_W-1:0] OP_SPARE_A = 3'd6;
    localparam logic [OP_W-1:0] OP_SPARE_B = 3'd7;

    typedef enum int {
        MODE_FLOOD,
        MODE_FILL,
        MODE_DRAIN,
        MODE_MIX
    } t_mix;

    logic i_clk;
    logic i_rst_n;

    usb_aat_if #(.t_payload(t_in_item))  req_if ();
    usb_aat_if #(.t_payload(t_out_item)) rsp_if ();

    usb_address_allocator_table u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    logic                occ_tbl   [TABLE_SIZE];
    logic [HANDLE_W-1:0] bound_tbl [TABLE_SIZE];
    logic [SPEED_W-1:0]  speed_tbl [TABLE_SIZE];
    logic [ADDR_W-1:0]   last_addr;

    t_in_item  request_q [$];
    t_out_item answer_q  [$];
    logic [HANDLE_W-1:0] handle_pool [6];

    int  issued_cnt   = 0;
    int  accepted_cnt = 0;
    int  err_cnt      = 0;
    int  idle_cycles  = 0;
    int  send_gap     = 0;
    int  hold_cnt     = 0;
    bit  req_taken    = 1'b0;
    bit  calm         = 1'b0;

    function automatic t_out_item serve_request(t_in_item rq);
        t_out_item         rs;
        logic [ADDR_W-1:0] cand;
        bit                done;
        rs   = '0;
        done = 1'b0;
        case (rq.op)
            OP_ALLOCATE: begin
                rs.status = ST_NO_SPACE;
                cand      = last_addr;
                for (int n = 0; n < TOP_ADDR && !done; n++) begin
                    cand = (cand >= ADDR_W'(TOP_ADDR)) ? ADDR_W'(1) : cand + 1'b1;
                    if (!occ_tbl[cand]) begin
                        occ_tbl[cand]     = 1'b1;
                        speed_tbl[cand]   = rq.dev_speed;
                        last_addr         = cand;
                        rs.status         = ST_OK;
                        rs.result_address = cand;
                        done              = 1'b1;
                    end
                end
            end
            OP_BIND, OP_RELEASE: begin
                if (rq.dev_address == '0 || !occ_tbl[rq.dev_address]) begin
                    rs.status = ST_BAD_REQUEST;
                end else begin
                    if (rq.op == OP_BIND) begin
                        bound_tbl[rq.dev_address] = rq.dev_handle;
                    end else begin
                        occ_tbl[rq.dev_address] = 1'b0;
                    end
                    rs.status = ST_OK;
                end
            end
            OP_FIND_HNDL: begin
                rs.status = ST_NOT_FOUND;
                for (int a = 1; a <= TOP_ADDR && !done; a++) begin
                    if (occ_tbl[a] && bound_tbl[a] == rq.dev_handle) begin
                        rs.status         = ST_OK;
                        rs.result_address = ADDR_W'(a);
                        done              = 1'b1;
                    end
                end
            end
            OP_FIND_ADDR: begin
                if (!occ_tbl[rq.dev_address]) begin
                    rs.status = ST_NOT_FOUND;
                end else begin
                    rs.status         = ST_OK;
                    rs.result_address = rq.dev_address;
                    rs.result_handle  = bound_tbl[rq.dev_address];
                end
            end
            OP_GET_SPEED: begin
                rs.status       = ST_OK;
                rs.result_speed = speed_tbl[rq.dev_address];
            end
            default: begin
                rs.status = ST_BAD_REQUEST;
            end
        endcase
        return rs;
    endfunction

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
        $display("MISMATCH at %0t ns: %s: got %0h, want %0h", $time, what, got, want);
        err_cnt++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 65) begin
            return 0;
        end else if (r < 92) begin
            return $urandom_range(1, 3);
        end
        return $urandom_range(8, 40);
    endfunction

    function automatic logic [ADDR_W-1:0] pick_busy_address();
        int start;
        int a;
        start = $urandom_range(1, TOP_ADDR);
        for (int k = 0; k < TOP_ADDR; k++) begin
            a = ((start - 1 + k) % TOP_ADDR) + 1;
            if (occ_tbl[a]) begin
                return ADDR_W'(a);
            end
        end
        return ADDR_W'($urandom_range(0, TOP_ADDR));
    endfunction

    function automatic logic [HANDLE_W-1:0] pick_handle();
        if ($urandom_range(0, 99) < 75) begin
            return handle_pool[$urandom_range(0, 5)];
        end
        return $urandom;
    endfunction

    function automatic logic [OP_W-1:0] pick_op(t_mix mix);
        int              wt [7];
        logic [OP_W-1:0] ops [7];
        int              r;
        ops = '{OP_ALLOCATE, OP_BIND, OP_RELEASE, OP_FIND_HNDL, OP_FIND_ADDR,
                OP_GET_SPEED, OP_SPARE_A};
        case (mix)
            MODE_FLOOD: wt = '{88, 4, 0, 3, 2, 2, 1};
            MODE_FILL:  wt = '{55, 15, 5, 10, 7, 6, 2};
            MODE_DRAIN: wt = '{8, 10, 45, 15, 10, 10, 2};
            default:    wt = '{25, 20, 20, 15, 10, 8, 2};
        endcase
        r = $urandom_range(0, 99);
        for (int k = 0; k < 7; k++) begin
            if (r < wt[k]) begin
                if (ops[k] == OP_SPARE_A && $urandom_range(0, 1) == 1) begin
                    return OP_SPARE_B;
                end
                return ops[k];
            end
            r -= wt[k];
        end
        return OP_ALLOCATE;
    endfunction

    task automatic push_request(logic [OP_W-1:0] op, logic [ADDR_W-1:0] addr,
                                logic [HANDLE_W-1:0] hnd, logic [SPEED_W-1:0] spd);
        t_in_item it;
        it.op          = op;
        it.dev_address = addr;
        it.dev_handle  = hnd;
        it.dev_speed   = spd;
        request_q.push_back(it);
        issued_cnt++;
    endtask

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
            req_if.data  <= '0;
        end else if (!req_if.valid || req_taken) begin
            if (send_gap > 0) begin
                send_gap--;
                req_if.valid <= 1'b0;
            end else if (request_q.size() != 0) begin
                req_if.valid <= 1'b1;
                req_if.data  <= request_q.pop_front();
                send_gap = pick_gap();
            end else begin
                req_if.valid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            rsp_if.ready <= 1'b0;
        end else if (hold_cnt > 0) begin
            hold_cnt--;
            rsp_if.ready <= 1'b0;
        end else begin
            rsp_if.ready <= 1'b1;
            hold_cnt = pick_gap();
        end
    end

    always @(posedge i_clk) begin
        t_out_item got;
        t_out_item want;
        if (!i_rst_n) begin
            for (int a = 0; a < TABLE_SIZE; a++) begin
                occ_tbl[a]   = 1'b0;
                bound_tbl[a] = '0;
                speed_tbl[a] = SPEED_UNKNOWN;
            end
            occ_tbl[0] = 1'b1;
            last_addr  = '0;
            req_taken  = 1'b0;
        end else begin
            req_taken = req_if.valid && req_if.ready;
            if (req_taken) begin
                answer_q.push_back(serve_request(req_if.data));
                accepted_cnt++;
            end
            if (rsp_if.valid && rsp_if.ready) begin
                got = rsp_if.data;
                if (answer_q.size() == 0) begin
                    report_mismatch("response with nothing outstanding", 64'(got), 64'd0);
                end else begin
                    want = answer_q.pop_front();
                    if (got.status !== want.status)
                        report_mismatch("status", 64'(got.status), 64'(want.status));
                    if (got.result_address !== want.result_address)
                        report_mismatch("result_address", 64'(got.result_address),
                                        64'(want.result_address));
                    if (got.result_handle !== want.result_handle)
                        report_mismatch("result_handle", 64'(got.result_handle),
                                        64'(want.result_handle));
                    if (got.result_speed !== want.result_speed)
                        report_mismatch("result_speed", 64'(got.result_speed),
                                        64'(want.result_speed));
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (req_if.valid && req_if.ready) || (rsp_if.valid && rsp_if.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial begin
        t_mix              mix;
        int                rand_cnt;
        int                phase_len;
        int                step;
        int                chunk;
        bit                first;
        logic [OP_W-1:0]   op;
        logic [ADDR_W-1:0] addr;
        logic [HANDLE_W-1:0] hnd;

        i_rst_n      = 1'b0;
        req_if.valid = 1'b0;
        req_if.data  = '0;
        rsp_if.ready = 1'b0;

        handle_pool[0] = '0;
        handle_pool[1] = '1;
        for (int k = 2; k < 6; k++) begin
            handle_pool[k] = $urandom;
        end

        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        push_request(OP_GET_SPEED, 7'd0, '0, 2'd0);
        push_request(OP_FIND_ADDR, 7'd0, '0, 2'd0);
        push_request(OP_FIND_HNDL, 7'd0, '0, 2'd0);
        push_request(OP_BIND, 7'd0, 32'h1234_5678, 2'd0);
        push_request(OP_RELEASE, 7'd0, '0, 2'd0);
        push_request(OP_BIND, 7'd5, '1, 2'd3);
        push_request(OP_RELEASE, 7'd127, '0, 2'd0);
        push_request(OP_FIND_ADDR, 7'd127, '0, 2'd0);
        push_request(OP_ALLOCATE, 7'd0, '0, 2'd0);
        push_request(OP_ALLOCATE, 7'd127, '1, 2'd1);
        push_request(OP_ALLOCATE, 7'd0, '0, 2'd2);
        push_request(OP_ALLOCATE, 7'd0, '0, 2'd3);
        push_request(OP_BIND, 7'd1, '1, 2'd0);
        push_request(OP_BIND, 7'd2, 32'hA5A5_5A5A, 2'd0);
        push_request(OP_FIND_HNDL, 7'd0, '1, 2'd0);
        push_request(OP_FIND_HNDL, 7'd0, '0, 2'd0);
        push_request(OP_FIND_ADDR, 7'd1, '0, 2'd0);
        push_request(OP_GET_SPEED, 7'd2, '0, 2'd0);
        push_request(OP_GET_SPEED, 7'd127, '0, 2'd0);
        push_request(OP_RELEASE, 7'd1, '0, 2'd0);
        push_request(OP_RELEASE, 7'd1, '0, 2'd0);
        push_request(OP_FIND_HNDL, 7'd0, '1, 2'd0);
        push_request(OP_SPARE_A, '1, '1, '1);
        push_request(OP_SPARE_B, '1, '1, '1);
        push_request(OP_ALLOCATE, 7'd0, '0, 2'd1);

        rand_cnt = 0;
        first    = 1'b1;
        while (rand_cnt < RANDOM_ITEMS) begin
            if (first) begin
                mix       = MODE_FLOOD;
                phase_len = 180;
                first     = 1'b0;
            end else begin
                mix       = t_mix'($urandom_range(0, 3));
                phase_len = $urandom_range(40, 220);
            end
            step = 0;
            while (step < phase_len && rand_cnt < RANDOM_ITEMS) begin
                chunk = $urandom_range(1, 8);
                repeat (chunk) begin
                    op   = pick_op(mix);
                    addr = ($urandom_range(0, 4) == 0) ? ADDR_W'($urandom_range(0, TOP_ADDR))
                                                       : pick_busy_address();
                    hnd  = pick_handle();
                    if (op == OP_FIND_HNDL && $urandom_range(0, 99) < 60) begin
                        hnd = bound_tbl[pick_busy_address()];
                    end
                    push_request(op, addr, hnd, SPEED_W'($urandom_range(0, 3)));
                    rand_cnt++;
                    step++;
                end
                if ($urandom_range(0, 99) < 4) begin
                    calm = !calm;
                end
                while (request_q.size() != 0) @(posedge i_clk);
            end
        end

        while (accepted_cnt != issued_cnt || answer_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (err_cnt == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
